FILE: hw/rtl/lpt_pkg.sv
// lookahead path tracker shared types, register indexes and constants
// no dependencies
package lpt_pkg;

  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_SPEED    = 3'd0,
    REG_YAW_GAIN      = 3'd1,
    REG_LOOKAHEAD     = 3'd2,
    REG_GOAL_TOL      = 3'd3,
    REG_REQUEST_DIST  = 3'd4,
    REG_OBST_THRESH   = 3'd5,
    REG_SECTOR_HALF   = 3'd6,
    REG_OBST_GAIN     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_POINT = 2'd0,
    OP_SCAN  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               first;
    logic signed [15:0] angle;
    logic [31:0]        beam_range;
    logic               range_finite;
    logic signed [15:0] speed_set;
    logic [7:0]         mode;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        speed;
    logic signed [31:0] yaw_rate;
    logic               goal_flag;
    logic               stopped;
  } out_item_t;

  typedef struct packed {
    logic [15:0] base_speed;
    logic [15:0] yaw_gain;
    logic [31:0] pass_radius;
    logic [31:0] stop_radius;
    logic [31:0] notify_radius;
    logic [31:0] obstacle_threshold;
    logic [14:0] sector_half_angle;
    logic [15:0] avoid_gain;
  } cfg_t;

  // distance compare selector
  typedef enum logic [1:0] {
    DSEL_REQ  = 2'd0,
    DSEL_TOL  = 2'd1,
    DSEL_LOOK = 2'd2,
    DSEL_NONE = 2'd3
  } dsel_t;

  // controller to datapath commands
  typedef struct packed {
    logic  latch_in;
    logic  load_diff;
    logic  load_sq;
    logic  load_cmp;
    dsel_t dsel;
    logic  cordic_init;
    logic  cordic_step;
    logic  load_err;
    logic  load_prod;
    logic  load_rate;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic less;
  } dp_sts_t;

  localparam int CordicSteps = 14;
  localparam int AngW        = 18;
  localparam int CordW       = 36;
  localparam logic signed [AngW-1:0] PiQ13     = 18'sd25736;
  localparam logic signed [AngW-1:0] TwoPiQ13  = 18'sd51472;
  localparam logic signed [AngW-1:0] HalfPiQ13 = 18'sd12868;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [3:0] i);
    logic signed [AngW-1:0] v;
    case (i)
      4'd0: v = 18'sd6434;
      4'd1: v = 18'sd3798;
      4'd2: v = 18'sd2007;
      4'd3: v = 18'sd1019;
      4'd4: v = 18'sd511;
      4'd5: v = 18'sd256;
      4'd6: v = 18'sd128;
      4'd7: v = 18'sd64;
      4'd8: v = 18'sd32;
      4'd9: v = 18'sd16;
      4'd10: v = 18'sd8;
      4'd11: v = 18'sd4;
      4'd12: v = 18'sd2;
      4'd13: v = 18'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/lpt_ram.sv
// generic single port ram with registered read
// no dependencies
module lpt_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/lpt_datapath.sv
// tick datapath: differences, squared distance compare, cordic atan2, yaw rate
// depends on lpt_pkg
module lpt_datapath
  import lpt_pkg::*;
(
  input  logic               clk,
  input  cfg_t               cfg,
  input  in_item_t           item,
  input  logic               obstacle,
  input  logic [63:0]        rd_point,
  input  dp_cmd_t            cmd,
  input  logic [3:0]         step,
  output dp_sts_t            sts,
  output logic signed [31:0] yaw_rate
);
  in_item_t           it;
  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay;
  logic [65:0]        a2, b2;
  logic [31:0]        dreg;
  logic               big;
  logic               less;
  logic signed [CordW-1:0] cx, cy;
  logic signed [AngW-1:0]  ang;
  logic signed [AngW-1:0]  err;
  logic signed [49:0]      prod;
  logic [31:0]             gain;

  logic [63:0]        pt;
  logic signed [32:0] ndx, ndy;
  logic [31:0]        dsel_val;
  logic [66:0]        ssum;
  logic [63:0]        dsq;
  logic signed [CordW-1:0] shx, shy;
  logic signed [AngW-1:0]  diff0, diff1;
  logic [49:0]             mag;
  logic [34:0]             rnd;

  assign pt  = rd_point;
  assign ndx = 33'(signed'(pt[63:32])) - 33'(it.pos_x);
  assign ndy = 33'(signed'(pt[31:0])) - 33'(it.pos_y);

  always_comb begin
    case (cmd.dsel)
      DSEL_REQ:  dsel_val = cfg.notify_radius;
      DSEL_TOL:  dsel_val = cfg.stop_radius;
      DSEL_LOOK: dsel_val = cfg.pass_radius;
      default:   dsel_val = '0;
    endcase
  end

  assign ssum = 67'(a2) + 67'(b2);
  assign dsq  = dreg * dreg;

  assign shx = cx >>> step;
  assign shy = cy >>> step;

  // heading of a zero vector is zero
  assign diff0 = ((dx == '0 && dy == '0) ? AngW'(0) : ang) - AngW'(it.angle);
  always_comb begin
    diff1 = diff0;
    if (diff0 > PiQ13) begin
      diff1 = diff0 - TwoPiQ13;
    end else if (diff0 < -PiQ13) begin
      diff1 = diff0 + TwoPiQ13;
    end
  end

  assign mag = prod[49] ? 50'(-prod) : 50'(prod);
  assign rnd = 35'((mag + 50'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      it <= item;
    end
    if (cmd.load_diff) begin
      dx <= ndx;
      dy <= ndy;
      ax <= ndx[32] ? 33'(-ndx) : 33'(ndx);
      ay <= ndy[32] ? 33'(-ndy) : 33'(ndy);
    end
    if (cmd.load_sq) begin
      a2   <= ax * ax;
      b2   <= ay * ay;
      dreg <= dsel_val;
      big  <= (ax >= 33'(dsel_val)) || (ay >= 33'(dsel_val));
    end
    if (cmd.load_cmp) begin
      less <= !big && (ssum < 67'(dsq));
    end
    if (cmd.cordic_init) begin
      ang <= '0;
      if (dx < 0) begin
        if (dy >= 0) begin
          cx <= CordW'(dy); cy <= -CordW'(dx); ang <= HalfPiQ13;
        end else begin
          cx <= -CordW'(dy); cy <= CordW'(dx); ang <= -HalfPiQ13;
        end
      end else begin
        cx <= CordW'(dx); cy <= CordW'(dy);
      end
    end else if (cmd.cordic_step) begin
      if (cy >= 0) begin
        cx <= cx + shy; cy <= cy - shx; ang <= ang + atan_lut(step);
      end else begin
        cx <= cx - shy; cy <= cy + shx; ang <= ang - atan_lut(step);
      end
    end
    if (cmd.load_err) begin
      err  <= diff1;
      gain <= obstacle ? 32'(cfg.yaw_gain) * 32'(cfg.avoid_gain)
                       : 32'({cfg.yaw_gain, 8'd0});
    end
    if (cmd.load_prod) begin
      prod <= 50'(signed'({1'b0, gain})) * 50'(err);
    end
    if (cmd.load_rate) begin
      if (rnd > 35'h7FFFFFFF) begin
        yaw_rate <= prod[49] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
        yaw_rate <= prod[49] ? -signed'(rnd[31:0]) : signed'(rnd[31:0]);
      end
    end
  end

  assign sts.less = less;
endmodule

FILE: hw/rtl/lpt_controller.sv
// tick sequencer and path, scan and goal bookkeeping
// depends on lpt_pkg
module lpt_controller
  import lpt_pkg::*;
#(
  parameter int PathDepth = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  in_item_t                     item,
  input  cfg_t                         cfg,
  input  dp_sts_t                      sts,
  output logic                         busy,
  output dp_cmd_t                      cmd,
  output logic [3:0]                   step,
  output logic                         obstacle,
  output logic                         ram_we,
  output logic [$clog2(PathDepth)-1:0] ram_addr,
  output logic                         done,
  output logic                         done_stop,
  output logic                         done_req
);
  localparam int AW = $clog2(PathDepth);
  localparam int CW = $clog2(PathDepth + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RDL   = 12'b000000000010,
    S_DIFF  = 12'b000000000100,
    S_SQ    = 12'b000000001000,
    S_CMP   = 12'b000000010000,
    S_JUDGE = 12'b000000100000,
    S_RDP   = 12'b000001000000,
    S_CORD  = 12'b000010000000,
    S_ERR   = 12'b000100000000,
    S_PROD  = 12'b001000000000,
    S_RATE  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [AW-1:0] tidx;
  logic          greq, req_now;
  logic [1:0]    phase;   // 0 req, 1 tol, 2 lookahead walk
  logic          walking;
  logic          accept;
  logic signed [15:0] h;
  logic [AW-1:0] last;

  assign accept = start && state == S_IDLE;
  assign busy   = state != S_IDLE;
  assign last   = AW'(count - CW'(1));
  assign h      = 16'(signed'({1'b0, cfg.sector_half_angle}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      tidx     <= '0;
      greq     <= 1'b0;
      obstacle <= 1'b0;
      req_now  <= 1'b0;
      phase    <= '0;
      step     <= '0;
      walking  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        req_now <= 1'b0;
        phase   <= '0;
        case (op_t'(item.op))
          OP_POINT: begin
            if (item.first) begin
              tidx <= '0;
              greq <= 1'b0;
              count <= CW'(1);
            end else if (count < CW'(PathDepth)) begin
              count <= count + CW'(1);
            end
          end
          OP_SCAN: begin
            if (item.angle > -h && item.angle < h && item.range_finite &&
                item.beam_range < cfg.obstacle_threshold) begin
              obstacle <= 1'b1;
            end else if (item.first) begin
              obstacle <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (state == S_JUDGE) begin
        case (phase)
          2'd0: begin
            if (!greq && sts.less) begin
              greq <= 1'b1;
              req_now <= 1'b1;
            end
            phase <= 2'd1;
          end
          2'd1: if (!sts.less) phase <= 2'd2;
          default: if (sts.less && walking) tidx <= tidx + AW'(1);
        endcase
      end
      if (state == S_RDP) begin
        walking <= tidx < last;
      end
      if (state == S_JUDGE && phase == 2'd1) begin
        walking <= tidx < last;
      end
      if (state == S_CORD) begin
        step <= step + 4'd1;
      end else begin
        step <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.dsel   = DSEL_NONE;
    ram_we     = 1'b0;
    ram_addr   = tidx;
    done       = 1'b0;
    done_stop  = 1'b0;
    done_req   = req_now;
    case (phase)
      2'd0:    cmd.dsel = DSEL_REQ;
      2'd1:    cmd.dsel = DSEL_TOL;
      default: cmd.dsel = DSEL_LOOK;
    endcase
    case (state)
      S_IDLE: begin
        done_req = 1'b0;
        if (start) begin
          cmd.latch_in = 1'b1;
          case (op_t'(item.op))
            OP_POINT: begin
              ram_addr = item.first ? '0 : AW'(count);
              ram_we   = item.first || count < CW'(PathDepth);
            end
            OP_TICK: begin
              if (item.mode >= 8'd2) begin
                if (count < CW'(2)) begin
                  state_next = S_OUT;
                end else begin
                  state_next = S_RDL;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RDL: begin
        ram_addr   = last;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.load_diff = 1'b1;
        state_next    = S_SQ;
      end
      S_SQ: begin
        cmd.load_sq = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        cmd.load_cmp = 1'b1;
        state_next   = S_JUDGE;
      end
      S_JUDGE: begin
        case (phase)
          2'd0: state_next = S_SQ;
          2'd1: begin
            if (sts.less) begin
              state_next = S_OUT;
            end else begin
              state_next = S_RDP;
            end
          end
          default: begin
            if (sts.less && walking) begin
              ram_addr   = tidx + AW'(1);
              state_next = S_RDP;
            end else begin
              cmd.cordic_init = 1'b1;
              state_next      = S_CORD;
            end
          end
        endcase
        if (phase == 2'd0) begin
          cmd.dsel = DSEL_TOL;
        end
      end
      S_RDP: begin
        state_next = S_DIFF;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        if (step == 4'(CordicSteps - 1)) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.load_err = 1'b1;
        state_next   = S_PROD;
      end
      S_PROD: begin
        cmd.load_prod = 1'b1;
        state_next    = S_RATE;
      end
      S_RATE: begin
        cmd.load_rate = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        done       = 1'b1;
        done_stop  = phase != 2'd2;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(PathDepth))
    else $error("point count overflow");
  assert property (@(posedge clk) disable iff (rst)
      count >= CW'(2) |-> tidx <= last)
    else $error("target index beyond last point");
  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after result");
endmodule

FILE: hw/rtl/lookahead_path_tracker.sv
// top level of the lookahead path tracker: config registers, waypoint ram,
// controller and datapath; depends on lpt_pkg, lpt_ram, lpt_controller, lpt_datapath
// points, scans and idle ticks stay idle and strobe no result; stop ticks strobe on a short
// path or inside goal tolerance; steering ticks rerun the rdp/diff/sq/cmp/judge distance
// test per passed waypoint; one item at a time, busy high until the result cycle (14 cordic
// steps); results cannot be stalled; sync reset restores register defaults, clears the path
module lookahead_path_tracker
  import lpt_pkg::*;
#(
  parameter int PATH_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = $clog2(PATH_DEPTH);

  cfg_t        cfg;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [3:0]  step;
  logic        obstacle, ram_we, done, done_stop, done_req;
  logic [AW-1:0] ram_addr;
  logic [63:0] rdata;
  logic signed [31:0] rate;
  in_item_t    it;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_speed         <= 16'd154;
      cfg.yaw_gain           <= 16'd768;
      cfg.pass_radius        <= 32'd65536;
      cfg.stop_radius        <= 32'd13107;
      cfg.notify_radius      <= 32'd65536;
      cfg.obstacle_threshold <= 32'd32768;
      cfg.sector_half_angle  <= 15'd4289;
      cfg.avoid_gain         <= 16'd768;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_SPEED:    cfg.base_speed         <= cfg_data[15:0];
        REG_YAW_GAIN:      cfg.yaw_gain           <= cfg_data[15:0];
        REG_LOOKAHEAD:     cfg.pass_radius        <= cfg_data;
        REG_GOAL_TOL:      cfg.stop_radius        <= cfg_data;
        REG_REQUEST_DIST:  cfg.notify_radius      <= cfg_data;
        REG_OBST_THRESH:   cfg.obstacle_threshold <= cfg_data;
        REG_SECTOR_HALF:   cfg.sector_half_angle  <= cfg_data[14:0];
        REG_OBST_GAIN:     cfg.avoid_gain         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      it <= in_item;
    end
  end

  lpt_ram #(.Width(64), .Depth(PATH_DEPTH)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr),
    .wdata({in_item.pos_x, in_item.pos_y}), .rdata
  );

  lpt_controller #(.PathDepth(PATH_DEPTH)) u_ctrl (
    .clk, .rst, .start, .item(in_item), .cfg, .sts, .busy, .cmd, .step,
    .obstacle, .ram_we, .ram_addr, .done, .done_stop, .done_req
  );

  lpt_datapath u_dp (
    .clk, .cfg, .item(in_item), .obstacle, .rd_point(rdata), .cmd, .step,
    .sts, .yaw_rate(rate)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= done;
    end
    out_item.goal_flag    <= done_req;
    out_item.stopped      <= done_stop;
    out_item.yaw_rate     <= done_stop ? '0 : rate;
    out_item.speed        <= done_stop ? '0 :
        (it.speed_set > 0 ? 16'(it.speed_set) : cfg.base_speed);
  end
endmodule
